// ===== hdl/vab_pkg.sv =====
// vab_pkg: shared types, constants and command codes for the voice allocator
// depends on nothing
package vab_pkg;

	localparam int NUM_VOICES = 8;
	localparam int VW = $clog2(NUM_VOICES);
	localparam logic [16:0] FULL_LEVEL = 17'd65536;

	typedef enum logic [2:0] {
		CMD_NOTE_ON  = 3'd0,
		CMD_OFF_NOTE = 3'd1,
		CMD_OFF_ID   = 3'd2,
		CMD_ALL_OFF  = 3'd3,
		CMD_TICK     = 3'd4,
		CMD_RESET    = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4
	} stage_t;

	localparam logic [1:0] REG_ATTACK  = 2'd0;
	localparam logic [1:0] REG_DECAY   = 2'd1;
	localparam logic [1:0] REG_SUSTAIN = 2'd2;
	localparam logic [1:0] REG_RELEASE = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic          latch;     // capture input word
		logic          bulk;      // run off/all_off/reset over all voices
		logic          note_on;   // write allocated voice
		logic          tick_load; // start envelope step of voice
		logic          div_start;
		logic          tick_done; // write back stepped voice
		logic [VW-1:0] voice;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_busy;
		logic need_div;
	} dp_sts_t;

endpackage

// ===== hdl/vab_div.sv =====
// vab_div: restoring divider, one quotient bit per cycle
// depends on nothing
module vab_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [39:0] dividend,
	input  logic [19:0] divisor,
	output logic [39:0] quotient,
	output logic        busy
);
	logic [39:0] q_q;
	logic [20:0] r_q;
	logic [19:0] d_q;
	logic [5:0]  cnt_q;
	logic [20:0] trial;

	assign trial = {r_q[19:0], q_q[39]};

	// shift-subtract step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd40;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != 6'd0) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				q_q <= {q_q[38:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[38:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 6'd0);
	assign quotient = q_q;
endmodule

// ===== hdl/vab_datapath.sv =====
// vab_datapath: voice table, config registers, envelope step and output register
// depends on vab_pkg and vab_div
module vab_datapath import vab_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_idx,
	input  logic [19:0]   cfg_data,
	input  logic [2:0]    command,
	input  logic [15:0]   note_id,
	input  logic [6:0]    midi_note,
	input  logic [8:0]    velocity,
	input  dp_cmd_t       cmd,
	output dp_sts_t       sts,
	output logic [VW-1:0] res_voice,
	output logic          res_active,
	output logic [2:0]    res_stage,
	output logic [16:0]   res_level,
	output logic [6:0]    res_note,
	output logic [8:0]    res_vel,
	output logic          res_stolen
);
	logic [19:0] att_q, dec_q, rel_q;
	logic [16:0] sus_q;
	stage_t      stage_q [NUM_VOICES];
	logic [19:0] cnt_q   [NUM_VOICES];
	logic [16:0] lvl_q   [NUM_VOICES];
	logic [16:0] rst_q   [NUM_VOICES];
	logic [15:0] id_q    [NUM_VOICES];
	logic [6:0]  note_q  [NUM_VOICES];
	logic [8:0]  vel_q   [NUM_VOICES];
	logic [31:0] age_q   [NUM_VOICES];
	logic [31:0] agec_q;
	logic [2:0]  c_q;
	logic [15:0] i_q;
	logic [6:0]  n_q;
	logic [8:0]  v_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q <= 20'd0; dec_q <= 20'd7938; sus_q <= 17'd49152; rel_q <= 20'd0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ATTACK:  att_q <= cfg_data;
				REG_DECAY:   dec_q <= cfg_data;
				REG_SUSTAIN: sus_q <= cfg_data[16:0];
				REG_RELEASE: rel_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			c_q <= command; i_q <= note_id; n_q <= midi_note; v_q <= velocity;
		end
	end

	logic [16:0] sus;
	assign sus = (sus_q > FULL_LEVEL) ? FULL_LEVEL : sus_q;

	// voice picker: first idle, else rank then age
	logic [VW-1:0] pick;
	logic          stolen;
	function automatic logic [2:0] rank(stage_t s);
		unique case (s)
			ST_RELEASE: rank = 3'd0;
			ST_SUSTAIN: rank = 3'd1;
			ST_DECAY:   rank = 3'd2;
			ST_ATTACK:  rank = 3'd3;
			default:    rank = 3'd4;
		endcase
	endfunction
	always_comb begin
		logic found;
		found = 1'b0;
		pick = '0;
		for (int v = NUM_VOICES - 1; v >= 0; v--) begin
			if (stage_q[v] == ST_IDLE) begin
				found = 1'b1;
				pick = VW'(v);
			end
		end
		stolen = !found;
		if (!found) begin
			for (int v = 1; v < NUM_VOICES; v++) begin
				if (rank(stage_q[v]) < rank(stage_q[pick]) ||
				    (rank(stage_q[v]) == rank(stage_q[pick]) && age_q[v] < age_q[pick]))
					pick = VW'(v);
			end
		end
	end

	// envelope step of selected voice: prepare divide operands
	logic [20:0] nxt;
	logic [19:0] len;
	logic [39:0] dvd;
	logic [19:0] div_d;
	logic [39:0] quo;
	logic        busy;
	stage_t      cs;
	assign cs = stage_q[cmd.voice];
	assign nxt = {1'b0, cnt_q[cmd.voice]} + 21'd1;
	always_comb begin
		len = rel_q;
		dvd = '0;
		unique case (cs)
			ST_ATTACK: begin
				len = att_q;
				dvd = {4'd0, nxt[19:0], 16'd0};
			end
			ST_DECAY: begin
				len = dec_q;
				dvd = 40'(FULL_LEVEL - sus) * 40'(nxt);
			end
			ST_RELEASE: begin
				len = rel_q;
				dvd = 40'(rst_q[cmd.voice]) * 40'(21'(rel_q) - nxt);
			end
			default: ;
		endcase
	end
	logic active_stage;
	assign active_stage = (cs == ST_ATTACK) || (cs == ST_DECAY) || (cs == ST_RELEASE);
	assign sts.need_div = active_stage && len != 20'd0 && nxt < 21'(len);
	assign div_d = len;

	logic [39:0] dvd_q;
	logic [19:0] dd_q;
	always_ff @(posedge clk) begin
		if (cmd.tick_load) begin
			dvd_q <= dvd; dd_q <= div_d;
		end
	end

	vab_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dvd_q), .divisor(dd_q), .quotient(quo), .busy(busy)
	);
	assign sts.div_busy = busy;

	// voice table update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agec_q <= '0;
			for (int v = 0; v < NUM_VOICES; v++) begin
				stage_q[v] <= ST_IDLE; cnt_q[v] <= '0; lvl_q[v] <= '0; rst_q[v] <= '0;
				id_q[v] <= '0; note_q[v] <= '0; vel_q[v] <= '0; age_q[v] <= '0;
			end
		end else if (cmd.bulk) begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				logic off;
				off = 1'b0;
				priority case (c_q)
					CMD_RESET: begin
						stage_q[v] <= ST_IDLE; cnt_q[v] <= '0; lvl_q[v] <= '0;
						rst_q[v] <= '0; id_q[v] <= '0; note_q[v] <= '0;
						vel_q[v] <= '0; age_q[v] <= '0;
					end
					CMD_ALL_OFF: off = stage_q[v] != ST_IDLE;
					default: begin
						// off by id, off by note, or zero velocity note-on
						if (stage_q[v] != ST_IDLE && stage_q[v] != ST_RELEASE) begin
							if (c_q == CMD_OFF_ID ||
							    (c_q == CMD_NOTE_ON && i_q != 16'd0))
								off = (i_q != 16'd0) && id_q[v] == i_q;
							else
								off = note_q[v] == n_q;
						end
					end
				endcase
				if (off) begin
					rst_q[v] <= lvl_q[v]; cnt_q[v] <= '0; stage_q[v] <= ST_RELEASE;
				end
			end
		end else if (cmd.note_on) begin
			id_q[pick] <= i_q; note_q[pick] <= n_q;
			vel_q[pick] <= (v_q > 9'd256) ? 9'd256 : v_q;
			lvl_q[pick] <= '0; rst_q[pick] <= '0; cnt_q[pick] <= '0;
			stage_q[pick] <= ST_ATTACK;
			agec_q <= agec_q + 32'd1;
			age_q[pick] <= agec_q + 32'd1;
		end else if (cmd.tick_done) begin
			unique case (cs)
				ST_ATTACK, ST_DECAY: begin
					if (sts.need_div) begin
						cnt_q[cmd.voice] <= nxt[19:0];
						lvl_q[cmd.voice] <= (cs == ST_ATTACK) ? quo[16:0] :
							FULL_LEVEL - quo[16:0];
					end else begin
						cnt_q[cmd.voice] <= '0;
						lvl_q[cmd.voice] <= (cs == ST_ATTACK) ? FULL_LEVEL : sus;
						stage_q[cmd.voice] <= (cs == ST_ATTACK) ? ST_DECAY : ST_SUSTAIN;
					end
				end
				ST_SUSTAIN: lvl_q[cmd.voice] <= sus;
				ST_RELEASE: begin
					if (sts.need_div && quo[16:0] != 17'd0) begin
						cnt_q[cmd.voice] <= nxt[19:0];
						lvl_q[cmd.voice] <= quo[16:0];
					end else begin
						stage_q[cmd.voice] <= ST_IDLE; cnt_q[cmd.voice] <= '0;
						lvl_q[cmd.voice] <= '0; rst_q[cmd.voice] <= '0;
						id_q[cmd.voice] <= '0; note_q[cmd.voice] <= '0;
						vel_q[cmd.voice] <= '0; age_q[cmd.voice] <= '0;
					end
				end
				default: lvl_q[cmd.voice] <= '0;
			endcase
		end
	end

	// result of note-on or tick step: captured voice and stolen flag
	logic [VW-1:0] rv_q;
	logic          rs_q;
	always_ff @(posedge clk) begin
		if (cmd.note_on) begin
			rv_q <= pick; rs_q <= stolen;
		end else if (cmd.tick_done) begin
			rv_q <= cmd.voice; rs_q <= 1'b0;
		end
	end
	assign res_voice  = rv_q;
	assign res_stolen = rs_q;
	assign res_stage  = stage_q[rv_q];
	assign res_active = stage_q[rv_q] != ST_IDLE;
	assign res_level  = lvl_q[rv_q];
	assign res_note   = note_q[rv_q];
	assign res_vel    = vel_q[rv_q];
endmodule

// ===== hdl/vab_ctrl.sv =====
// vab_ctrl: sequencer for command decode, per-voice envelope walk and result handshake
// depends on vab_pkg
module vab_ctrl import vab_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    command,
	input  logic [8:0]    velocity,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          out_last,
	output dp_cmd_t       cmd,
	input  dp_sts_t       sts
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DEC   = 7'b0000010,
		S_LOAD  = 7'b0000100,
		S_START = 7'b0001000,
		S_WAIT  = 7'b0010000,
		S_WB    = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t        st_q;
	logic [2:0]    c_q;
	logic          zv_q;
	logic [VW-1:0] v_q;
	logic          tick_q;

	assign in_ready = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign out_last = !tick_q || v_q == VW'(NUM_VOICES - 1);

	always_comb begin
		cmd = '0;
		cmd.voice = v_q;
		cmd.latch = in_valid && in_ready;
		cmd.bulk = (st_q == S_DEC) && (c_q == CMD_OFF_NOTE || c_q == CMD_OFF_ID ||
			c_q == CMD_ALL_OFF || c_q == CMD_RESET || (c_q == CMD_NOTE_ON && zv_q));
		cmd.note_on = (st_q == S_DEC) && c_q == CMD_NOTE_ON && !zv_q;
		cmd.tick_load = (st_q == S_LOAD);
		cmd.div_start = (st_q == S_START);
		cmd.tick_done = (st_q == S_WB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; c_q <= '0; zv_q <= 1'b0; v_q <= '0; tick_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: if (in_valid) begin
					c_q <= command; zv_q <= velocity == 9'd0; st_q <= S_DEC;
				end
				S_DEC: begin
					v_q <= '0;
					tick_q <= c_q == CMD_TICK;
					if (c_q == CMD_TICK) st_q <= S_LOAD;
					else if (c_q == CMD_NOTE_ON && !zv_q) st_q <= S_OUT;
					else st_q <= S_IDLE;
				end
				S_LOAD:  st_q <= sts.need_div ? S_START : S_WB;
				S_START: st_q <= S_WAIT;
				S_WAIT:  if (!sts.div_busy) st_q <= S_WB;
				S_WB:    st_q <= S_OUT;
				S_OUT: if (out_ready) begin
					if (tick_q && v_q != VW'(NUM_VOICES - 1)) begin
						v_q <= v_q + VW'(1); st_q <= S_LOAD;
					end else begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q))
		else $error("state not one-hot");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_START |=> st_q == S_WAIT) else $error("divider start skipped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
endmodule

// ===== hdl/voice_allocator_adsr_bank_core.sv =====
// Voice allocator with per-voice linear ADSR envelopes, eight voices. One word at a
// time: a note-on is decoded and then presents its result; off, all-off and reset are
// applied in decode and return to idle with no result; a tick walks the voices one by
// one, each step loading operands, starting and waiting on the shared bit-serial divider
// when it divides, then writing back and presenting that voice's result.
// Configuration writes through cfg_we/cfg_idx/cfg_data belong between words only, while
// the block is idle and no result is pending.
// top level: instantiates vab_ctrl and vab_datapath, depends on vab_pkg
module voice_allocator_adsr_bank_core import vab_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [19:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [15:0] note_id,
	input  logic [6:0]  midi_note,
	input  logic [8:0]  velocity,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  voice_index,
	output logic        voice_active,
	output logic [2:0]  env_stage,
	output logic [16:0] env_level,
	output logic [6:0]  voice_note,
	output logic [8:0]  voice_velocity,
	output logic        voice_stolen,
	output logic        last
);
	dp_cmd_t       cmd;
	dp_sts_t       sts;
	logic [VW-1:0] rv;

	vab_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.command(command), .velocity(velocity), .out_valid(out_valid),
		.out_ready(out_ready), .out_last(last), .cmd(cmd), .sts(sts)
	);

	vab_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .command(command), .note_id(note_id),
		.midi_note(midi_note), .velocity(velocity), .cmd(cmd), .sts(sts),
		.res_voice(rv), .res_active(voice_active), .res_stage(env_stage),
		.res_level(env_level), .res_note(voice_note), .res_vel(voice_velocity),
		.res_stolen(voice_stolen)
	);

	assign voice_index = 6'(rv);
endmodule
